@@ sv/ipid_pkg.sv @@
package ipid_pkg;

	localparam int SPEED_W    = 16;
	localparam int ERR_W      = SPEED_W + 1;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int DUTY_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DUTY_FRAC_BITS_DEF = 8;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd5888;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd1050;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd0;
	localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd1000;
	localparam logic [LIM_W-1:0]  DUTY_LIMIT_RST  = 15'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_DUTY_LIMIT  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]  integ_limit;
		logic [LIM_W-1:0]  duty_limit;
	} cfg_t;

endpackage

@@ sv/ipid_cfg.sv @@
module ipid_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data,
	output ipid_pkg::cfg_t                  cfg
);
	import ipid_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.deriv_gain  <= DERIV_GAIN_RST;
			cfg_q.integ_limit <= INTEG_LIMIT_RST;
			cfg_q.duty_limit  <= DUTY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_data[LIM_W-1:0];
				REG_DUTY_LIMIT:  cfg_q.duty_limit  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/ipid_calc.sv @@
module ipid_calc #(
	parameter int DUTY_FRAC_BITS = ipid_pkg::DUTY_FRAC_BITS_DEF,
	localparam int ACC_W = ipid_pkg::LIM_W + DUTY_FRAC_BITS + 1
) (
	input  ipid_pkg::cfg_t                          cfg,
	input  logic signed [ipid_pkg::ERR_W-1:0]       err,
	input  logic signed [ipid_pkg::ERR_W-1:0]       last_err,
	input  logic signed [ipid_pkg::ERR_W-1:0]       prev_err,
	input  logic signed [ACC_W-1:0]                 duty_accum,
	output logic signed [ACC_W-1:0]                 duty_next,
	output logic signed [ipid_pkg::DUTY_W-1:0]      drive_duty,
	output logic                                    at_limit
);
	import ipid_pkg::*;

	localparam int D1_W   = ERR_W + 1;
	localparam int D2_W   = ERR_W + 2;
	localparam int PP_W   = GAIN_W + 1 + D1_W;
	localparam int IP_W   = GAIN_W + 1 + ERR_W;
	localparam int DP_W   = GAIN_W + 1 + D2_W;
	localparam int IT_W   = LIM_W + 8 + 1;
	localparam int INC_W  = DP_W + 1;
	localparam int UP     = (DUTY_FRAC_BITS >= 8) ? DUTY_FRAC_BITS - 8 : 0;
	localparam int DN     = (DUTY_FRAC_BITS < 8) ? 8 - DUTY_FRAC_BITS : 0;
	localparam int SC_W   = INC_W + UP;
	localparam int ND_W   = ((SC_W > ACC_W) ? SC_W : ACC_W) + 1;
	localparam int LIMV_W = LIM_W + DUTY_FRAC_BITS;

	logic signed [D1_W-1:0]   d1;
	logic signed [D2_W-1:0]   d2;
	logic signed [PP_W-1:0]   p_prod;
	logic signed [IP_W-1:0]   i_prod;
	logic signed [DP_W-1:0]   d_prod;
	logic signed [IT_W-1:0]   ilim_s;
	logic signed [IT_W-1:0]   iterm;
	logic signed [INC_W-1:0]  inc;
	logic signed [SC_W-1:0]   inc_ext;
	logic signed [SC_W-1:0]   scaled;
	logic [LIMV_W-1:0]        lim_u;
	logic signed [ND_W-1:0]   lim_s;
	logic signed [ND_W-1:0]   nd;
	logic signed [ND_W-1:0]   nd_sat;
	logic signed [ND_W-1:0]   mag;
	logic [DUTY_W-1:0]        ip;
	logic                     neg;

	always_comb begin
		d1 = D1_W'(err) - D1_W'(last_err);
		d2 = D2_W'(err) - (D2_W'(last_err) <<< 1) + D2_W'(prev_err);

		p_prod = PP_W'(signed'({1'b0, cfg.prop_gain}))  * PP_W'(d1);
		i_prod = IP_W'(signed'({1'b0, cfg.integ_gain})) * IP_W'(err);
		d_prod = DP_W'(signed'({1'b0, cfg.deriv_gain})) * DP_W'(d2);

		ilim_s = signed'({1'b0, cfg.integ_limit, 8'd0});
		if (i_prod > IP_W'(ilim_s))
			iterm = ilim_s;
		else if (i_prod < -IP_W'(ilim_s))
			iterm = -ilim_s;
		else
			iterm = IT_W'(i_prod);

		inc     = INC_W'(p_prod) + INC_W'(iterm) + INC_W'(d_prod);
		inc_ext = SC_W'(inc);
		scaled  = (inc_ext <<< UP) >>> DN;

		lim_u = LIMV_W'(cfg.duty_limit) << DUTY_FRAC_BITS;
		lim_s = ND_W'(signed'({1'b0, lim_u}));
		nd    = ND_W'(duty_accum) + ND_W'(scaled);

		at_limit = 1'b0;
		if (nd > lim_s) begin
			nd_sat   = lim_s;
			at_limit = 1'b1;
		end else if (nd < -lim_s) begin
			nd_sat   = -lim_s;
			at_limit = 1'b1;
		end else begin
			nd_sat = nd;
		end

		duty_next  = ACC_W'(nd_sat);
		neg        = nd_sat[ND_W-1];
		mag        = neg ? -nd_sat : nd_sat;
		ip         = DUTY_W'(mag >> DUTY_FRAC_BITS);
		drive_duty = neg ? -signed'(ip) : signed'(ip);
	end

endmodule

@@ sv/incremental_pid_speed_loop_top.sv @@
// Velocity-form PID speed loop for one wheel. Each input transaction carries a target and
// a measured encoder speed; each yields exactly one result transaction with the integer
// duty (truncated toward zero) and a flag set when the duty was clipped to +/- duty_limit.
// The block accepts one transaction per cycle while results are taken; a result is
// presented once its input has passed the input register and one compute pass into the
// result register, and can be taken at the next edge. A stalled result holds the
// input register, which then drops in_ready. The error history and accumulated duty update
// in that same compute pass. Gains are
// unsigned Q8.8; the duty keeps DUTY_FRAC_BITS fraction bits internally. Configuration
// registers reset to their defaults and should be written only while the block is idle.
module incremental_pid_speed_loop_top #(
	parameter int DUTY_FRAC_BITS = ipid_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [ipid_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ipid_pkg::SPEED_W-1:0]   target_speed,
	input  logic signed [ipid_pkg::SPEED_W-1:0]   measured_speed,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ipid_pkg::DUTY_W-1:0]    drive_duty,
	output logic                                  duty_at_limit
);
	import ipid_pkg::*;

	localparam int ACC_W = LIM_W + DUTY_FRAC_BITS + 1;

	cfg_t                     cfg;
	logic                     valid_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic                     valid_s2;
	logic signed [DUTY_W-1:0] drive_duty_s2;
	logic                     at_limit_s2;
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ACC_W-1:0]  duty_accum_q;
	logic signed [ACC_W-1:0]  duty_next;
	logic signed [DUTY_W-1:0] drive_next;
	logic                     at_limit_next;
	logic                     advance;

	ipid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipid_calc #(
		.DUTY_FRAC_BITS (DUTY_FRAC_BITS)
	) u_calc (
		.cfg        (cfg),
		.err        (err_s1),
		.last_err   (last_err_q),
		.prev_err   (prev_err_q),
		.duty_accum (duty_accum_q),
		.duty_next  (duty_next),
		.drive_duty (drive_next),
		.at_limit   (at_limit_next)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			err_s1 <= ERR_W'(target_speed) - ERR_W'(measured_speed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			last_err_q   <= '0;
			prev_err_q   <= '0;
			duty_accum_q <= '0;
		end else begin
			if (advance) begin
				valid_s2     <= 1'b1;
				last_err_q   <= err_s1;
				prev_err_q   <= last_err_q;
				duty_accum_q <= duty_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_duty_s2 <= drive_next;
			at_limit_s2   <= at_limit_next;
		end
	end

	assign out_valid     = valid_s2;
	assign drive_duty    = drive_duty_s2;
	assign duty_at_limit = at_limit_s2;

	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (last_err_q == $past(err_s1)) && (prev_err_q == $past(last_err_q)))
		else $error("error history did not shift");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> $stable(duty_accum_q) && $stable(last_err_q))
		else $error("loop state moved while result stalled");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && at_limit_next) |->
			((drive_next == signed'(DUTY_W'(cfg.duty_limit))) ||
			 (drive_next == -signed'(DUTY_W'(cfg.duty_limit)))))
		else $error("clipped duty not at limit");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(err_s1))
		else $error("staged input lost");

endmodule
